// File: sv/csstat_pkg.sv
// ----------------------------------------------------------------------------
// Channel sample statistics package
// Shared widths, record and result types, and the result engine states.
// ----------------------------------------------------------------------------
package csstat_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 24;
  localparam int unsigned FRAC_BITS   = 8;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned STD_W    = 24;

  localparam int unsigned SUM_W     = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned ABS_W     = SUM_W - 1;
  localparam int unsigned SQR_W     = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SQSUM_W   = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
  localparam int unsigned NUM_W     = COUNT_BITS + SQSUM_W;
  localparam int unsigned DEN_W     = 2 * COUNT_BITS;
  localparam int unsigned DVD_W     = NUM_W + 2 * FRAC_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int unsigned MUL_CNT_W = $clog2(ABS_W + 1);
  localparam int unsigned ROOT_W    = 64;
  localparam int unsigned QX_W      = (DVD_W > ROOT_W) ? DVD_W : ROOT_W + 1;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [QX_W-1:0] MEAN_NEG_X = QX_W'(1) << (MEAN_W - 1);
  localparam logic [QX_W-1:0] MEAN_POS_X = MEAN_NEG_X - QX_W'(1);
  localparam logic [ROOT_W-1:0] ROOT_ONE_INIT = ROOT_W'(1) << (ROOT_W - 2);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       invalid;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         total_count;
    logic [COUNT_W-1:0]         bad_count;
    logic                       has_finite;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [SAMPLE_W-1:0]        max_magnitude;
    logic signed [MEAN_W-1:0]   mean_value;
    logic [STD_W-1:0]           std_dev;
    logic                       overflow;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]         seen;
    logic [COUNT_BITS-1:0]         bad;
    logic [COUNT_BITS-1:0]         vcnt;
    logic signed [SAMPLE_BITS-1:0] min_v;
    logic signed [SAMPLE_BITS-1:0] max_v;
    logic [SAMPLE_BITS-1:0]        mag;
    logic signed [SUM_W-1:0]       sum;
    logic [SQSUM_W-1:0]            sumsq;
    logic                          sat;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MEAN,
    S_MSQ,
    S_MKS,
    S_DIFF,
    S_VAR,
    S_ROOT,
    S_OUT
  } back_state_e;

endpackage

// File: sv/csstat_front.sv
// ----------------------------------------------------------------------------
// Channel sample statistics front end
// Registers each sample with its square, then folds it into the running
// counts, extremes and exact sums; pushes a record summary on the last sample.
// ----------------------------------------------------------------------------
module csstat_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  csstat_pkg::in_item_t  in_data_i,
  output logic                  push_o,
  output csstat_pkg::rec_t      push_data_o,
  input  logic                  full_i
);

  logic                                     s1_valid_q, s1_valid_d;
  logic signed [csstat_pkg::SAMPLE_BITS-1:0] s1_val_q;
  logic [csstat_pkg::SQR_W-1:0]             s1_sqr_q;
  logic                                     s1_inv_q, s1_last_q;

  logic [csstat_pkg::COUNT_BITS-1:0]        seen_q, seen_d, bad_q, bad_d, vcnt_q, vcnt_d;
  logic signed [csstat_pkg::SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [csstat_pkg::SAMPLE_BITS-1:0]       mag_q, mag_d;
  logic signed [csstat_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [csstat_pkg::SQSUM_W-1:0]           sumsq_q, sumsq_d;
  logic                                     sat_q, sat_d;

  logic signed [csstat_pkg::SAMPLE_BITS-1:0]   in_val;
  logic signed [2*csstat_pkg::SAMPLE_BITS-1:0] in_sqr;
  logic [csstat_pkg::SAMPLE_BITS:0]            val_ext, val_mag;
  logic                                        stall, accept, step;
  csstat_pkg::rec_t                            upd;

  assign stall      = s1_valid_q && s1_last_q && full_i;
  assign in_ready_o = !stall;
  assign accept     = in_valid_i && in_ready_o;
  assign step       = s1_valid_q && !stall;
  assign s1_valid_d = accept || stall;

  assign in_val = in_data_i.sample[csstat_pkg::SAMPLE_BITS-1:0];
  assign in_sqr = in_val * in_val;

  assign val_ext = {s1_val_q[csstat_pkg::SAMPLE_BITS-1], s1_val_q};
  assign val_mag = s1_val_q[csstat_pkg::SAMPLE_BITS-1] ? (~val_ext + 1'b1) : val_ext;

  always_comb begin
    upd       = '0;
    upd.seen  = seen_q;
    upd.bad   = bad_q;
    upd.vcnt  = vcnt_q;
    upd.min_v = min_q;
    upd.max_v = max_q;
    upd.mag   = mag_q;
    upd.sum   = sum_q;
    upd.sumsq = sumsq_q;
    upd.sat   = sat_q;
    if (seen_q == csstat_pkg::COUNT_MAX) begin
      upd.sat = 1'b1;
    end else begin
      upd.seen = seen_q + 1'b1;
    end
    if (s1_inv_q) begin
      if (bad_q == csstat_pkg::COUNT_MAX) begin
        upd.sat = 1'b1;
      end else begin
        upd.bad = bad_q + 1'b1;
      end
    end else begin
      if (s1_val_q < min_q) begin
        upd.min_v = s1_val_q;
      end
      if (s1_val_q > max_q) begin
        upd.max_v = s1_val_q;
      end
      if (val_mag[csstat_pkg::SAMPLE_BITS-1:0] > mag_q) begin
        upd.mag = val_mag[csstat_pkg::SAMPLE_BITS-1:0];
      end
      if (vcnt_q == csstat_pkg::COUNT_MAX) begin
        upd.sat = 1'b1;
      end else begin
        upd.vcnt  = vcnt_q + 1'b1;
        upd.sum   = sum_q + csstat_pkg::SUM_W'(s1_val_q);
        upd.sumsq = sumsq_q + csstat_pkg::SQSUM_W'(s1_sqr_q);
      end
    end
  end

  always_comb begin
    seen_d  = seen_q;
    bad_d   = bad_q;
    vcnt_d  = vcnt_q;
    min_d   = min_q;
    max_d   = max_q;
    mag_d   = mag_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    sat_d   = sat_q;
    if (step) begin
      if (s1_last_q) begin
        seen_d  = '0;
        bad_d   = '0;
        vcnt_d  = '0;
        min_d   = csstat_pkg::MIN_RESET;
        max_d   = csstat_pkg::MAX_RESET;
        mag_d   = '0;
        sum_d   = '0;
        sumsq_d = '0;
        sat_d   = 1'b0;
      end else begin
        seen_d  = upd.seen;
        bad_d   = upd.bad;
        vcnt_d  = upd.vcnt;
        min_d   = upd.min_v;
        max_d   = upd.max_v;
        mag_d   = upd.mag;
        sum_d   = upd.sum;
        sumsq_d = upd.sumsq;
        sat_d   = upd.sat;
      end
    end
  end

  assign push_o      = step && s1_last_q;
  assign push_data_o = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      seen_q     <= '0;
      bad_q      <= '0;
      vcnt_q     <= '0;
      min_q      <= csstat_pkg::MIN_RESET;
      max_q      <= csstat_pkg::MAX_RESET;
      mag_q      <= '0;
      sum_q      <= '0;
      sumsq_q    <= '0;
      sat_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      seen_q     <= seen_d;
      bad_q      <= bad_d;
      vcnt_q     <= vcnt_d;
      min_q      <= min_d;
      max_q      <= max_d;
      mag_q      <= mag_d;
      sum_q      <= sum_d;
      sumsq_q    <= sumsq_d;
      sat_q      <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_val_q  <= in_val;
      s1_sqr_q  <= in_sqr[csstat_pkg::SQR_W-1:0];
      s1_inv_q  <= in_data_i.invalid;
      s1_last_q <= in_data_i.last;
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("record pushed into a full queue");

  a_clear_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (seen_q == '0 && bad_q == '0 && vcnt_q == '0 && !sat_q))
    else $error("statistics not cleared after the last sample");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vcnt_q <= seen_q) && (bad_q <= seen_q))
    else $error("partial count exceeds total count");
`endif

endmodule

// File: sv/csstat_fifo.sv
// ----------------------------------------------------------------------------
// Channel sample statistics record queue
// Short queue of record summaries between the front end and result engine.
// ----------------------------------------------------------------------------
module csstat_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csstat_pkg::rec_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output csstat_pkg::rec_t  head_o,
  output logic              empty_o
);

  csstat_pkg::rec_t                  mem_q [csstat_pkg::FIFO_DEPTH];
  logic [csstat_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [csstat_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = cnt_q == csstat_pkg::FIFO_CNT_W'(csstat_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == csstat_pkg::FIFO_PTR_W'(csstat_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == csstat_pkg::FIFO_PTR_W'(csstat_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/csstat_div.sv
// ----------------------------------------------------------------------------
// Channel sample statistics divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csstat_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [csstat_pkg::DVD_W-1:0]   dividend_i,
  input  logic [csstat_pkg::DEN_W-1:0]   divisor_i,
  output logic                           idle_o,
  output logic [csstat_pkg::DVD_W-1:0]   quotient_o
);

  logic [csstat_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [csstat_pkg::DVD_W-1:0]     sh_q;
  logic [csstat_pkg::DEN_W-1:0]     rem_q, dvs_q;
  logic [csstat_pkg::DEN_W:0]       trial, diff;
  logic                             qbit;

  assign idle_o     = cnt_q == '0;
  assign quotient_o = sh_q;
  assign trial      = {rem_q, sh_q[csstat_pkg::DVD_W-1]};
  assign diff       = trial - {1'b0, dvs_q};
  assign qbit       = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = csstat_pkg::DIV_CNT_W'(csstat_pkg::DVD_W);
    end else if (!idle_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (!idle_o) begin
      sh_q  <= {sh_q[csstat_pkg::DVD_W-2:0], qbit};
      rem_q <= qbit ? diff[csstat_pkg::DEN_W-1:0] : trial[csstat_pkg::DEN_W-1:0];
    end
  end

endmodule

// File: sv/csstat_back.sv
// ----------------------------------------------------------------------------
// Channel sample statistics result engine
// Takes one record summary at a time and works out the mean and standard
// deviation with a shared divider, a shift-add multiplier and a root unit.
// ----------------------------------------------------------------------------
module csstat_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csstat_pkg::rec_t       head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output csstat_pkg::out_item_t  out_data_o
);

  csstat_pkg::back_state_e state_q, state_d;
  csstat_pkg::rec_t        rec_q;

  logic [csstat_pkg::DEN_W-1:0]      kk_q;
  logic signed [csstat_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic [csstat_pkg::STD_W-1:0]      std_q;
  logic [csstat_pkg::NUM_W-1:0]      acc_q, sq_q;
  logic [csstat_pkg::ABS_W-1:0]      mpl_q;
  logic [csstat_pkg::SQSUM_W-1:0]    mcd_q;
  logic [csstat_pkg::MUL_CNT_W-1:0]  mcnt_q;
  logic [csstat_pkg::ROOT_W-1:0]     x_q, res_q, one_q, root_trial, root_in;

  logic [csstat_pkg::SUM_W-1:0]      sum_mag;
  logic [csstat_pkg::ABS_W-1:0]      abs_sum;
  logic [csstat_pkg::COUNT_BITS-1:0] vcnt_m1;
  logic [csstat_pkg::NUM_W:0]        diff_w;
  logic [csstat_pkg::NUM_W-1:0]      num;
  logic [csstat_pkg::QX_W-1:0]       q_ext;
  logic [csstat_pkg::DVD_W-1:0]      div_dvd, div_q;
  logic [csstat_pkg::DEN_W-1:0]      div_dvs;
  logic                              div_start, div_idle;
  logic                              k_zero, k_one, mul_run, root_run;
  logic                              mul_load_sq, mul_load_ks, root_load, mean_take, std_take;

  assign k_zero   = rec_q.vcnt == '0;
  assign k_one    = rec_q.vcnt == csstat_pkg::COUNT_BITS'(1);
  assign mul_run  = (state_q == csstat_pkg::S_MSQ || state_q == csstat_pkg::S_MKS) &&
                    mcnt_q != '0;
  assign root_run = state_q == csstat_pkg::S_ROOT && one_q != '0;

  assign sum_mag = rec_q.sum[csstat_pkg::SUM_W-1] ? (~rec_q.sum + 1'b1) : rec_q.sum;
  assign abs_sum = sum_mag[csstat_pkg::ABS_W-1:0];
  assign vcnt_m1 = rec_q.vcnt - 1'b1;
  assign diff_w  = {1'b0, acc_q} - {1'b0, sq_q};
  assign num     = diff_w[csstat_pkg::NUM_W] ? '0 : diff_w[csstat_pkg::NUM_W-1:0];
  assign q_ext   = csstat_pkg::QX_W'(div_q);
  assign root_in = (|q_ext[csstat_pkg::QX_W-1:csstat_pkg::ROOT_W]) ?
                   '1 : q_ext[csstat_pkg::ROOT_W-1:0];
  assign root_trial = res_q + one_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      csstat_pkg::S_IDLE: begin
        if (!empty_i) state_d = csstat_pkg::S_LOAD;
      end
      csstat_pkg::S_LOAD: begin
        state_d = k_zero ? csstat_pkg::S_OUT : csstat_pkg::S_MEAN;
      end
      csstat_pkg::S_MEAN: begin
        if (div_idle) state_d = k_one ? csstat_pkg::S_OUT : csstat_pkg::S_MSQ;
      end
      csstat_pkg::S_MSQ: begin
        if (mcnt_q == '0) state_d = csstat_pkg::S_MKS;
      end
      csstat_pkg::S_MKS: begin
        if (mcnt_q == '0) state_d = csstat_pkg::S_DIFF;
      end
      csstat_pkg::S_DIFF: begin
        state_d = csstat_pkg::S_VAR;
      end
      csstat_pkg::S_VAR: begin
        if (div_idle) state_d = csstat_pkg::S_ROOT;
      end
      csstat_pkg::S_ROOT: begin
        if (one_q == '0) state_d = csstat_pkg::S_OUT;
      end
      csstat_pkg::S_OUT: begin
        if (out_ready_i) state_d = csstat_pkg::S_IDLE;
      end
      default: begin
        state_d = csstat_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    div_start   = 1'b0;
    div_dvd     = csstat_pkg::DVD_W'(num) << (2 * csstat_pkg::FRAC_BITS);
    div_dvs     = kk_q;
    mul_load_sq = 1'b0;
    mul_load_ks = 1'b0;
    root_load   = 1'b0;
    mean_take   = 1'b0;
    std_take    = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      csstat_pkg::S_IDLE: begin
        pop_o = !empty_i;
      end
      csstat_pkg::S_LOAD: begin
        div_start = !k_zero;
        div_dvd   = csstat_pkg::DVD_W'(abs_sum) << csstat_pkg::FRAC_BITS;
        div_dvs   = csstat_pkg::DEN_W'(rec_q.vcnt);
      end
      csstat_pkg::S_MEAN: begin
        mean_take   = div_idle;
        mul_load_sq = div_idle && !k_one;
      end
      csstat_pkg::S_MSQ: begin
        mul_load_ks = mcnt_q == '0;
      end
      csstat_pkg::S_DIFF: begin
        div_start = 1'b1;
      end
      csstat_pkg::S_VAR: begin
        root_load = div_idle;
      end
      csstat_pkg::S_ROOT: begin
        std_take = one_q == '0;
      end
      csstat_pkg::S_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (!rec_q.sum[csstat_pkg::SUM_W-1]) begin
      mean_d = (q_ext > csstat_pkg::MEAN_POS_X) ?
               csstat_pkg::MEAN_W'(csstat_pkg::MEAN_POS_X) : q_ext[csstat_pkg::MEAN_W-1:0];
    end else begin
      mean_d = (q_ext > csstat_pkg::MEAN_NEG_X) ?
               csstat_pkg::MEAN_W'(csstat_pkg::MEAN_NEG_X) :
               (~q_ext[csstat_pkg::MEAN_W-1:0] + 1'b1);
    end
  end

  csstat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .idle_o     (div_idle),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csstat_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= head_i;
    end
    if (state_q == csstat_pkg::S_LOAD) begin
      kk_q  <= csstat_pkg::DEN_W'(rec_q.vcnt) * csstat_pkg::DEN_W'(vcnt_m1);
      std_q <= '0;
    end
    if (mean_take) begin
      mean_q <= mean_d;
    end
    if (mul_load_sq) begin
      acc_q  <= '0;
      mpl_q  <= abs_sum;
      mcd_q  <= csstat_pkg::SQSUM_W'(abs_sum);
      mcnt_q <= csstat_pkg::MUL_CNT_W'(csstat_pkg::ABS_W);
    end else if (mul_load_ks) begin
      sq_q   <= acc_q;
      acc_q  <= '0;
      mpl_q  <= csstat_pkg::ABS_W'(rec_q.vcnt) << (csstat_pkg::ABS_W - csstat_pkg::COUNT_BITS);
      mcd_q  <= rec_q.sumsq;
      mcnt_q <= csstat_pkg::MUL_CNT_W'(csstat_pkg::COUNT_BITS);
    end else if (mul_run) begin
      acc_q  <= (acc_q << 1) +
                (mpl_q[csstat_pkg::ABS_W-1] ? csstat_pkg::NUM_W'(mcd_q) : '0);
      mpl_q  <= mpl_q << 1;
      mcnt_q <= mcnt_q - 1'b1;
    end
    if (root_load) begin
      x_q   <= root_in;
      res_q <= '0;
      one_q <= csstat_pkg::ROOT_ONE_INIT;
    end else if (root_run) begin
      if (x_q >= root_trial) begin
        x_q   <= x_q - root_trial;
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
    if (std_take) begin
      std_q <= (|res_q[csstat_pkg::ROOT_W-1:csstat_pkg::STD_W]) ?
               '1 : res_q[csstat_pkg::STD_W-1:0];
    end
  end

  always_comb begin
    out_data_o               = '0;
    out_data_o.total_count   = csstat_pkg::COUNT_W'(rec_q.seen);
    out_data_o.bad_count     = csstat_pkg::COUNT_W'(rec_q.bad);
    out_data_o.overflow      = rec_q.sat;
    if (!k_zero) begin
      out_data_o.has_finite    = 1'b1;
      out_data_o.min_value     = csstat_pkg::SAMPLE_W'(rec_q.min_v);
      out_data_o.max_value     = csstat_pkg::SAMPLE_W'(rec_q.max_v);
      out_data_o.max_magnitude = csstat_pkg::SAMPLE_W'(rec_q.mag);
      out_data_o.mean_value    = mean_q;
      out_data_o.std_dev       = std_q;
    end
  end

`ifndef SYNTHESIS
  a_div_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_idle) else $error("divider restarted while busy");

  a_mean_nonzero_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csstat_pkg::S_MEAN) |-> !k_zero)
    else $error("mean division with zero valid samples");

  a_var_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csstat_pkg::S_DIFF) |-> (kk_q > csstat_pkg::DEN_W'(1)))
    else $error("variance divisor below two");
`endif

endmodule

// File: sv/channel_sample_statistics.sv
// Flow: a record summary passes from the front-end stage through the record queue into
// the result engine's record register; the result then takes two divisions, two multiplies
// and a root computation, fewer when the record has at most one valid sample.
// Throughput: one sample per cycle; a two-entry record queue absorbs short records, and
// input stalls only when a last sample meets a full queue.
// Reset: asynchronous, active low; clears control state and the running statistics.
// ----------------------------------------------------------------------------
// Channel sample statistics
// Streams signed samples of one channel and reports counts, extremes, mean
// and sample standard deviation for each record.
// ----------------------------------------------------------------------------
module channel_sample_statistics (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  csstat_pkg::in_item_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output csstat_pkg::out_item_t  out_data_o
);

  logic             push, full, pop, empty;
  csstat_pkg::rec_t push_data, head;

  csstat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  csstat_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  csstat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
